// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the UTF-8 decoder.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/utf8dv_pkg.sv -----
// Types and constants for the UTF-8 decoder and codepoint search block.
// No dependencies.
package utf8dv_pkg;

    localparam int CP_BITS   = 21;
    localparam int IDX_BITS  = 24;
    localparam int BLEN_BITS = 3;

    // Configuration register indexes on the write port.
    localparam logic CFG_TARGET = 1'b0;
    localparam logic CFG_ENABLE = 1'b1;

    // Result kinds carried on the output tuser.
    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_BAD_LEAD = 2'd1,
        KIND_BAD_CONT = 2'd2,
        KIND_TRUNC    = 2'd3
    } kind_t;

    // Byte class masks and patterns.
    localparam logic [7:0] ASCII_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;

    // One result item.
    typedef struct packed {
        kind_t                 kind;
        logic [CP_BITS-1:0]    codepoint;
        logic [IDX_BITS-1:0]   char_index;
        logic [BLEN_BITS-1:0]  byte_length;
        logic                  is_match;
        logic                  stream_done;
        logic [IDX_BITS-1:0]   char_count;
        logic                  match_found;
        logic [IDX_BITS-1:0]   first_match_index;
    } result_t;

    // Search configuration handed to the decode core.
    typedef struct packed {
        logic [CP_BITS-1:0] target;
        logic               enable;
    } search_cfg_t;

endpackage

// ----- rtl/utf8_decode_validate_search.sv -----
// UTF-8 decoder with codepoint search: one byte per cycle while s_tready is high, zero or one result per byte.
// Each result is registered in the output register, or in the skid register while that one is stalled.
// The decode core is combinational; its state registers and counters update on each accepted byte.
// A two-entry output stage (result register plus skid register) keeps s_tready high while one result waits.
// Reset (rst_n, asynchronous, active low) clears the stream state, the output stage and both config registers.
// Depends on utf8dv_pkg, utf8dv_core and assert_macros.svh.
`include "assert_macros.svh"

module utf8_decode_validate_search #(
    parameter int INDEX_BITS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    // Configuration write port.
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [20:0]  cfg_data,
    // Byte stream in.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] byte_in
    input  logic         s_tlast,   // end_of_stream
    // Result stream out.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // codepoint, char_index, byte_length, is_match,
                                    // char_count, match_found, first_match_index, zero pad
    output logic [1:0]   m_tuser,   // [1:0] result_kind
    output logic         m_tlast    // stream_done
);

    logic [20:0]             target_reg;
    logic                    enable_reg;
    utf8dv_pkg::search_cfg_t cfg;
    logic                    accept;
    logic                    res_valid;
    utf8dv_pkg::result_t     res;
    logic                    load;
    logic                    pop;
    utf8dv_pkg::result_t     out_reg;
    logic                    out_valid_reg;
    utf8dv_pkg::result_t     skid_reg;
    logic                    skid_valid_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                utf8dv_pkg::CFG_TARGET: target_reg <= cfg_data;
                utf8dv_pkg::CFG_ENABLE: enable_reg <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    assign cfg.target = target_reg;
    assign cfg.enable = enable_reg;

    // Input transfer and decode.
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    utf8dv_core #(
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .byte_in   (s_tdata),
        .last      (s_tlast),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register with a skid register behind it.
    assign load = accept && res_valid;
    assign pop  = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= load;
            end
        end
        else if (load)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (load)
            begin
                out_reg <= res;
            end
        end
        else if (load)
        begin
            skid_reg <= res;
        end
    end

    // Pack the result onto the master side.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.stream_done;
    assign m_tdata  = {6'd0,
                       out_reg.first_match_index,
                       out_reg.match_found,
                       out_reg.char_count,
                       out_reg.is_match,
                       out_reg.byte_length,
                       out_reg.char_index,
                       out_reg.codepoint};

    // Checks on the output stage and configuration.
    `ASSERT_ALWAYS(a_skid_behind_out, skid_valid_reg |-> out_valid_reg, "skid entry without an output entry")
    `ASSERT_NEVER(a_no_overflow, skid_valid_reg && load, "result arrived with both entries full")
    `ASSERT_ALWAYS(a_cfg_enable, (cfg_we && cfg_index == utf8dv_pkg::CFG_ENABLE) |=> (enable_reg == $past(cfg_data[0])), "search enable write lost")

endmodule

// ----- rtl/utf8dv_core.sv -----
// Decode core: byte classification, codepoint assembly, counters and search.
// Depends on utf8dv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module utf8dv_core #(
    parameter int INDEX_BITS = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             byte_in,
    input  logic                   last,
    input  utf8dv_pkg::search_cfg_t cfg,
    output logic                   res_valid,
    output utf8dv_pkg::result_t    res
);

    localparam logic [INDEX_BITS-1:0] CNT_MAX = {INDEX_BITS{1'b1}};

    // Stream state.
    logic [1:0]                     rem_reg, rem_next;
    logic [utf8dv_pkg::CP_BITS-1:0] part_reg, part_next;
    logic [2:0]                     seqlen_reg, seqlen_next;
    logic [INDEX_BITS-1:0]          count_reg, count_next;
    logic [INDEX_BITS-1:0]          first_reg, first_next;
    logic                           seen_reg, seen_next;
    logic                           err_reg, err_next;

    // Decode intermediates.
    logic                           do_finish;
    logic                           do_error;
    utf8dv_pkg::kind_t              err_kind;
    logic [2:0]                     blen;
    logic [utf8dv_pkg::CP_BITS-1:0] cp;
    logic [utf8dv_pkg::CP_BITS-1:0] cp_cont;
    logic [1:0]                     rem_dec;
    logic                           match;
    logic [INDEX_BITS-1:0]          count_inc;
    logic [INDEX_BITS-1:0]          first_upd;
    logic                           seen_upd;

    assign cp_cont   = {part_reg[utf8dv_pkg::CP_BITS-7:0], byte_in[5:0]};
    assign rem_dec   = rem_reg - 2'd1;
    assign match     = cfg.enable && (cp == cfg.target);
    assign count_inc = (count_reg == CNT_MAX) ? count_reg : count_reg + INDEX_BITS'(1);
    assign seen_upd  = seen_reg | match;
    assign first_upd = (match && !seen_reg) ? count_reg : first_reg;

    // Classify the byte and decide on a finished character or an error.
    always_comb
    begin
        do_finish   = 1'b0;
        do_error    = 1'b0;
        err_kind    = utf8dv_pkg::KIND_BAD_LEAD;
        blen        = 3'd1;
        cp          = '0;
        rem_next    = rem_reg;
        part_next   = part_reg;
        seqlen_next = seqlen_reg;
        if (err_reg)
        begin
            // Bytes are dropped until the end of the stream.
        end
        else if (rem_reg == 2'd0)
        begin
            if ((byte_in & utf8dv_pkg::ASCII_MASK) == 8'h00)
            begin
                do_finish = 1'b1;
                cp        = utf8dv_pkg::CP_BITS'(byte_in);
                blen      = 3'd1;
            end
            else if ((byte_in & utf8dv_pkg::LEAD2_MASK) == utf8dv_pkg::LEAD2_PAT)
            begin
                part_next   = utf8dv_pkg::CP_BITS'(byte_in[4:0]);
                rem_next    = 2'd1;
                seqlen_next = 3'd2;
            end
            else if ((byte_in & utf8dv_pkg::LEAD3_MASK) == utf8dv_pkg::LEAD3_PAT)
            begin
                part_next   = utf8dv_pkg::CP_BITS'(byte_in[3:0]);
                rem_next    = 2'd2;
                seqlen_next = 3'd3;
            end
            else if ((byte_in & utf8dv_pkg::LEAD4_MASK) == utf8dv_pkg::LEAD4_PAT)
            begin
                part_next   = utf8dv_pkg::CP_BITS'(byte_in[2:0]);
                rem_next    = 2'd3;
                seqlen_next = 3'd4;
            end
            else
            begin
                do_error = 1'b1;
                err_kind = utf8dv_pkg::KIND_BAD_LEAD;
                blen     = 3'd1;
            end
            // A multi-byte lead on the end byte is a truncation.
            if (!do_finish && !do_error && last)
            begin
                do_error = 1'b1;
                err_kind = utf8dv_pkg::KIND_TRUNC;
                blen     = seqlen_next;
            end
        end
        else if ((byte_in & utf8dv_pkg::CONT_MASK) != utf8dv_pkg::CONT_PAT)
        begin
            do_error = 1'b1;
            err_kind = utf8dv_pkg::KIND_BAD_CONT;
            blen     = seqlen_reg;
        end
        else if (rem_dec == 2'd0)
        begin
            do_finish = 1'b1;
            cp        = cp_cont;
            blen      = seqlen_reg;
        end
        else if (last)
        begin
            do_error = 1'b1;
            err_kind = utf8dv_pkg::KIND_TRUNC;
            blen     = seqlen_reg;
        end
        else
        begin
            part_next = cp_cont;
            rem_next  = rem_dec;
        end
        // A finished character, an error or the end byte drops the partial character.
        if (do_finish || do_error || last)
        begin
            rem_next    = 2'd0;
            part_next   = '0;
            seqlen_next = 3'd0;
        end
    end

    // Result item and the remaining state updates.
    always_comb
    begin
        res_valid  = do_finish || do_error;
        count_next = count_reg;
        first_next = first_reg;
        seen_next  = seen_reg;
        err_next   = err_reg;

        res.kind              = do_finish ? utf8dv_pkg::KIND_CHAR : err_kind;
        res.codepoint         = do_finish ? cp : '0;
        res.char_index        = utf8dv_pkg::IDX_BITS'(count_reg);
        res.byte_length       = blen;
        res.is_match          = do_finish && match;
        res.stream_done       = last;
        res.char_count        = utf8dv_pkg::IDX_BITS'(count_reg);
        res.match_found       = seen_reg;
        res.first_match_index = utf8dv_pkg::IDX_BITS'(first_reg);

        if (do_finish)
        begin
            count_next            = count_inc;
            seen_next             = seen_upd;
            first_next            = first_upd;
            res.char_count        = utf8dv_pkg::IDX_BITS'(count_inc);
            res.match_found       = seen_upd;
            res.first_match_index = utf8dv_pkg::IDX_BITS'(first_upd);
        end
        if (do_error)
        begin
            err_next = 1'b1;
        end
        // The end byte restarts the stream after its result is formed.
        if (last)
        begin
            count_next  = '0;
            first_next  = '0;
            seen_next   = 1'b0;
            err_next    = 1'b0;
        end
    end

    // State registers advance on each accepted transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= 2'd0;
            part_reg   <= '0;
            seqlen_reg <= 3'd0;
            count_reg  <= '0;
            first_reg  <= '0;
            seen_reg   <= 1'b0;
            err_reg    <= 1'b0;
        end
        else if (accept)
        begin
            rem_reg    <= rem_next;
            part_reg   <= part_next;
            seqlen_reg <= seqlen_next;
            count_reg  <= count_next;
            first_reg  <= first_next;
            seen_reg   <= seen_next;
            err_reg    <= err_next;
        end
    end

    // Checks on the decode state.
    `ASSERT_ALWAYS(a_latched_silent, err_reg |-> !res_valid, "result produced while error latched")
    `ASSERT_ALWAYS(a_idle_clear, (rem_reg == 2'd0) |-> (part_reg == '0 && seqlen_reg == 3'd0), "stale partial character with no bytes pending")
    `ASSERT_ALWAYS(a_first_clear, !seen_reg |-> (first_reg == '0), "first match index set without a match")
    `ASSERT_ALWAYS(a_error_latches, (accept && res_valid && res.kind != utf8dv_pkg::KIND_CHAR && !last) |=> err_reg, "error did not latch")

endmodule
